// File: sv/asgr_pkg.sv
// Package for the ANSI SGR escape parser.
// Holds the byte codes, parse phase codes and the result item type.
// No dependencies.
package asgr_pkg;

    localparam logic [7:0] ESC_BYTE   = 8'd27;
    localparam logic [7:0] LBRACK     = 8'h5B;
    localparam logic [7:0] SEMI       = 8'h3B;
    localparam logic [7:0] FINAL_M    = 8'h6D;
    localparam logic [7:0] DIGIT_LO   = 8'h30;
    localparam logic [7:0] DIGIT_HI   = 8'h39;

    localparam logic [7:0] CODE_RESET = 8'd0;
    localparam logic [7:0] CODE_BOLD  = 8'd1;
    localparam logic [7:0] CODE_UL    = 8'd4;
    localparam logic [7:0] FG_LO      = 8'd30;
    localparam logic [7:0] FG_HI      = 8'd37;
    localparam logic [7:0] BG_LO      = 8'd40;
    localparam logic [7:0] BG_HI      = 8'd47;

    localparam logic signed [3:0] COLOR_DEFAULT = -4'sd1;

    localparam logic [1:0] PHASE_IDLE  = 2'd0;
    localparam logic [1:0] PHASE_ESC   = 2'd1;
    localparam logic [1:0] PHASE_PARAM = 2'd2;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_ATTR = 1'b1;

    localparam int TDATA_W = 24;

    typedef struct packed {
        logic signed [3:0] attr_background;
        logic signed [3:0] attr_foreground;
        logic              attr_underline;
        logic              attr_bold;
        logic [7:0]        out_byte;
        logic              event_kind;
    } result_t;

endpackage

// File: sv/asgr_in_stage.sv
// Input register of the ANSI SGR escape parser.
// Depends on nothing but the handshake from the parse stage.
module asgr_in_stage (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] text_byte
    input  logic       take_i,
    output logic       valid_o,
    output logic [7:0] byte_o
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;

    assign s_tready = !in_valid_reg || take_i;
    assign valid_o  = in_valid_reg;
    assign byte_o   = in_byte_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
        end
    end

endmodule

// File: sv/asgr_parse.sv
// Parse state and next-state logic of the ANSI SGR escape parser.
// Uses asgr_pkg; state advances by one byte when step_i is high.
module asgr_parse (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            step_i,
    input  logic [7:0]      byte_i,
    output asgr_pkg::result_t res_o,
    output logic            has_res_o
);
    import asgr_pkg::*;

    logic [1:0]        phase_reg, phase_next;
    logic [7:0]        acc_reg, acc_next;
    logic              present_reg, present_next;
    logic              bold_reg, bold_next;
    logic              ul_reg, ul_next;
    logic signed [3:0] fg_reg, fg_next;
    logic signed [3:0] bg_reg, bg_next;

    logic [11:0] acc_mul;
    logic [7:0]  code;

    assign code    = acc_reg;
    assign acc_mul = 12'(acc_reg) * 12'd10 + 12'(byte_i - DIGIT_LO);

    always_comb begin
        phase_next   = phase_reg;
        acc_next     = acc_reg;
        present_next = present_reg;
        bold_next    = bold_reg;
        ul_next      = ul_reg;
        fg_next      = fg_reg;
        bg_next      = bg_reg;
        has_res_o    = 1'b0;
        res_o        = '0;
        res_o.event_kind = KIND_BYTE;
        res_o.out_byte   = byte_i;

        case (phase_reg)
            PHASE_ESC: begin
                if (byte_i == LBRACK) begin
                    bold_next    = 1'b0;
                    ul_next      = 1'b0;
                    fg_next      = COLOR_DEFAULT;
                    bg_next      = COLOR_DEFAULT;
                    acc_next     = '0;
                    present_next = 1'b0;
                    phase_next   = PHASE_PARAM;
                end else begin
                    phase_next = PHASE_IDLE;
                    has_res_o  = 1'b1;
                end
            end
            PHASE_PARAM: begin
                if (byte_i == SEMI || byte_i == FINAL_M) begin
                    if (byte_i == FINAL_M) begin
                        phase_next = PHASE_IDLE;
                        has_res_o  = 1'b1;
                    end
                    if (present_reg) begin
                        acc_next     = '0;
                        present_next = 1'b0;
                        if (code == CODE_BOLD) begin
                            bold_next = 1'b1;
                        end else if (code == CODE_UL) begin
                            ul_next = 1'b1;
                        end else if (code inside {[FG_LO:FG_HI]}) begin
                            fg_next = 4'(code - FG_LO);
                        end else if (code inside {[BG_LO:BG_HI]}) begin
                            bg_next = 4'(code - BG_LO);
                        end else if (code == CODE_RESET) begin
                            bold_next  = 1'b0;
                            ul_next    = 1'b0;
                            fg_next    = COLOR_DEFAULT;
                            bg_next    = COLOR_DEFAULT;
                            phase_next = PHASE_IDLE;
                            has_res_o  = 1'b1;
                        end
                    end
                    if (has_res_o) begin
                        res_o.event_kind      = KIND_ATTR;
                        res_o.out_byte        = '0;
                        res_o.attr_bold       = bold_next;
                        res_o.attr_underline  = ul_next;
                        res_o.attr_foreground = fg_next;
                        res_o.attr_background = bg_next;
                    end
                end else if (byte_i inside {[DIGIT_LO:DIGIT_HI]}) begin
                    acc_next     = (acc_mul > 12'd255) ? 8'd255 : acc_mul[7:0];
                    present_next = 1'b1;
                end else begin
                    phase_next = PHASE_IDLE;
                    has_res_o  = 1'b1;
                end
            end
            default: begin
                if (byte_i == ESC_BYTE) begin
                    phase_next = PHASE_ESC;
                end else begin
                    phase_next = PHASE_IDLE;
                    has_res_o  = 1'b1;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PHASE_IDLE;
            acc_reg     <= '0;
            present_reg <= 1'b0;
            bold_reg    <= 1'b0;
            ul_reg      <= 1'b0;
            fg_reg      <= COLOR_DEFAULT;
            bg_reg      <= COLOR_DEFAULT;
        end else if (step_i) begin
            phase_reg   <= phase_next;
            acc_reg     <= acc_next;
            present_reg <= present_next;
            bold_reg    <= bold_next;
            ul_reg      <= ul_next;
            fg_reg      <= fg_next;
            bg_reg      <= bg_next;
        end
    end

endmodule

// File: sv/asgr_out_stage.sv
// Result register of the ANSI SGR escape parser.
// Uses asgr_pkg for the result item type.
module asgr_out_stage (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   load_i,
    input  asgr_pkg::result_t      res_i,
    output logic                   free_o,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [asgr_pkg::TDATA_W-1:0] m_tdata, // [7:0] out_byte, [8] attr_bold,
                                                  // [9] attr_underline,
                                                  // [13:10] attr_foreground,
                                                  // [17:14] attr_background
    output logic                   m_tuser   // [0] event_kind
);
    import asgr_pkg::*;

    logic    out_valid_reg;
    result_t out_res_reg;

    assign free_o   = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.event_kind;
    assign m_tdata  = {6'd0, out_res_reg.attr_background, out_res_reg.attr_foreground,
                       out_res_reg.attr_underline, out_res_reg.attr_bold,
                       out_res_reg.out_byte};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (free_o) begin
            out_valid_reg <= load_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (free_o && load_i) begin
            out_res_reg <= res_i;
        end
    end

endmodule

// File: sv/ansi_sgr_escape_parser_top.sv
// Top level of the ANSI SGR escape parser.
// Instantiates asgr_in_stage, asgr_parse and asgr_out_stage; uses asgr_pkg.
//
//   channel | dir | tdata                                    | tuser
//   s_      | in  | [7:0] text_byte                          | -
//   m_      | out | out_byte, bold, underline, fg, bg (24b)  | event_kind
//
// One byte per cycle sustained while m_tready does not stall the output.
// The input register feeds the parse logic, whose result lands in the output register.
// A byte that yields no result retires without waiting on the output side.
// Reset (aresetn low, synchronous) empties both registers and sets the parse state to idle.
// A stall on m_tready holds the result and backs up to s_tready in the same cycle.
module ansi_sgr_escape_parser_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] text_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [asgr_pkg::TDATA_W-1:0] m_tdata, // [7:0] out_byte, [8] attr_bold,
                                                  // [9] attr_underline,
                                                  // [13:10] attr_foreground,
                                                  // [17:14] attr_background
    output logic        m_tuser    // [0] event_kind
);
    import asgr_pkg::*;

    logic       item_valid;
    logic [7:0] item_byte;
    logic       take;
    logic       out_free;
    logic       has_res;
    result_t    res;

    assign take = item_valid && (!has_res || out_free);

    asgr_in_stage u_in (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .take_i   (take),
        .valid_o  (item_valid),
        .byte_o   (item_byte)
    );

    asgr_parse u_parse (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_i    (take),
        .byte_i    (item_byte),
        .res_o     (res),
        .has_res_o (has_res)
    );

    asgr_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load_i   (take && has_res),
        .res_i    (res),
        .free_o   (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
